### src/tnrn_pkg.sv
// Package for the telnet receive negotiator: codes, result and state types.
// No dependencies; used by tnrn_core, tnrn_serializer and the top level.
package tnrn_pkg;

    localparam int MAX_RES = 5;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [7:0] BYTE_IAC   = 8'hFF;
    localparam logic [7:0] CMD_EOR    = 8'd239;
    localparam logic [7:0] CMD_SE     = 8'd240;
    localparam logic [7:0] CMD_LASTSA = 8'd249;
    localparam logic [7:0] CMD_SB     = 8'd250;
    localparam logic [7:0] CMD_WILL   = 8'd251;
    localparam logic [7:0] CMD_WONT   = 8'd252;
    localparam logic [7:0] CMD_DO     = 8'd253;
    localparam logic [7:0] CMD_DONT   = 8'd254;

    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;
    localparam logic [7:0] OPT_TMARK  = 8'd6;
    localparam logic [7:0] OPT_TTYPE  = 8'd24;
    localparam logic [7:0] OPT_EOR    = 8'd25;
    localparam logic [7:0] OPT_NENV   = 8'd39;

    localparam logic [1:0] LINK_DOWN = 2'd0;
    localparam logic [1:0] LINK_NEG  = 2'd1;
    localparam logic [1:0] LINK_UP   = 2'd2;

    typedef enum logic [1:0] {
        OP_RX         = 2'd0,
        OP_CONNECT    = 2'd1,
        OP_DISCONNECT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_IAC  = 2'd1,
        PH_CMD  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_SUB    = 3'd1,
        KIND_REPLY  = 3'd2,
        KIND_SUBEND = 3'd3,
        KIND_LINK   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] reply_cmd;
        logic [7:0] reply_opt;
        logic [7:0] sub_option;
        logic [1:0] conn_state;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] list;
        logic [CNT_W-1:0]      count;
    } batch_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } ser_status_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] held_command;
        logic       in_subneg;
        logic [7:0] subneg_option;
        logic       binary_done;
        logic       eor_done;
        logic       termtype_sent;
        logic       handshake_done;
        logic [1:0] link_state;
    } state_t;

    function automatic result_t make_res(kind_t k, logic [7:0] db, logic [7:0] rc,
                                         logic [7:0] ro, logic [7:0] so, logic [1:0] cs);
        result_t r;
        r.kind       = k;
        r.data_byte  = db;
        r.reply_cmd  = rc;
        r.reply_opt  = ro;
        r.sub_option = so;
        r.conn_state = cs;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

### src/tnrn_rx_if.sv
// Input channel: one received byte or socket event per request.
// Depends on nothing.
interface tnrn_rx_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

### src/tnrn_res_if.sv
// Result channel: one result item per transfer.
// Depends on nothing.
interface tnrn_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] reply_cmd;
    logic [7:0] reply_opt;
    logic [7:0] sub_option;
    logic [1:0] conn_state;
    logic       last;

    modport source (output valid, output kind, output data_byte, output reply_cmd,
                    output reply_opt, output sub_option, output conn_state,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input reply_cmd,
                    input reply_opt, input sub_option, input conn_state,
                    input last, output ready);
endinterface

### src/tnrn_core.sv
// Telnet parser and negotiation state: state registers and the per-request
// result batch. Depends on tnrn_pkg.
module tnrn_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [1:0]      operation,
    input  logic [7:0]      rx_byte,
    output tnrn_pkg::batch_t batch
);

    tnrn_pkg::state_t state_reg;
    tnrn_pkg::state_t state_next;

    always_comb
    begin
        tnrn_pkg::state_t                         s;
        tnrn_pkg::result_t [tnrn_pkg::MAX_RES-1:0] res;
        logic [tnrn_pkg::CNT_W-1:0]               n;
        logic                                     do_pass;
        logic                                     do_check;
        logic                                     replied;
        logic                                     good;

        s        = state_reg;
        res      = '0;
        n        = '0;
        do_pass  = 1'b0;
        do_check = 1'b0;
        replied  = 1'b0;
        good     = 1'b0;

        unique case (tnrn_pkg::op_t'(operation))
            tnrn_pkg::OP_RX:
            begin
                unique case (s.phase)
                    tnrn_pkg::PH_IAC:
                    begin
                        s.phase = tnrn_pkg::PH_DATA;
                        if (rx_byte == tnrn_pkg::BYTE_IAC)
                        begin
                            do_pass = 1'b1;
                        end
                        else if (rx_byte >= tnrn_pkg::CMD_EOR && rx_byte <= tnrn_pkg::CMD_LASTSA)
                        begin
                            if (rx_byte == tnrn_pkg::CMD_SE && s.in_subneg)
                            begin
                                s.in_subneg = 1'b0;
                                res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_SUBEND, 8'd0, 8'd0,
                                                            8'd0, s.subneg_option, 2'd0);
                                n = n + 1'b1;
                                if (s.subneg_option == tnrn_pkg::OPT_TTYPE)
                                begin
                                    s.termtype_sent = 1'b1;
                                    s.binary_done   = 1'b1;
                                    do_check        = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            s.held_command = rx_byte;
                            s.phase        = tnrn_pkg::PH_CMD;
                        end
                    end
                    tnrn_pkg::PH_CMD:
                    begin
                        s.phase = tnrn_pkg::PH_DATA;
                        if (s.held_command == tnrn_pkg::CMD_WILL)
                        begin
                            good = rx_byte == tnrn_pkg::OPT_BINARY || rx_byte == tnrn_pkg::OPT_EOR
                                || rx_byte == tnrn_pkg::OPT_ECHO || rx_byte == tnrn_pkg::OPT_SGA;
                            res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_REPLY, 8'd0,
                                good ? tnrn_pkg::CMD_DO : tnrn_pkg::CMD_DONT, rx_byte,
                                8'd0, 2'd0);
                            n       = n + 1'b1;
                            replied = 1'b1;
                        end
                        else if (s.held_command == tnrn_pkg::CMD_DO)
                        begin
                            good = rx_byte == tnrn_pkg::OPT_BINARY || rx_byte == tnrn_pkg::OPT_EOR
                                || rx_byte == tnrn_pkg::OPT_TTYPE || rx_byte == tnrn_pkg::OPT_NENV;
                            res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_REPLY, 8'd0,
                                good ? tnrn_pkg::CMD_WILL : tnrn_pkg::CMD_WONT, rx_byte,
                                8'd0, 2'd0);
                            n       = n + 1'b1;
                            replied = 1'b1;
                        end
                        else if (s.held_command == tnrn_pkg::CMD_SB)
                        begin
                            s.in_subneg     = 1'b1;
                            s.subneg_option = rx_byte;
                        end
                        if (replied && rx_byte == tnrn_pkg::OPT_BINARY)
                        begin
                            s.binary_done = 1'b1;
                            do_check      = 1'b1;
                        end
                        else if (replied && rx_byte == tnrn_pkg::OPT_EOR)
                        begin
                            s.eor_done = 1'b1;
                            do_check   = 1'b1;
                        end
                    end
                    default:
                    begin
                        s.phase = tnrn_pkg::PH_DATA;
                        if (rx_byte == tnrn_pkg::BYTE_IAC)
                            s.phase = tnrn_pkg::PH_IAC;
                        else
                            do_pass = 1'b1;
                    end
                endcase

                if (do_check && !s.handshake_done && s.binary_done && s.termtype_sent)
                begin
                    s.handshake_done = 1'b1;
                    if (s.link_state != tnrn_pkg::LINK_UP)
                    begin
                        s.link_state = tnrn_pkg::LINK_UP;
                        res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_LINK, 8'd0, 8'd0, 8'd0,
                                                    8'd0, tnrn_pkg::LINK_UP);
                        n = n + 1'b1;
                    end
                end

                if (do_pass && s.in_subneg)
                begin
                    res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_SUB, rx_byte, 8'd0, 8'd0,
                                                8'd0, 2'd0);
                    n = n + 1'b1;
                end
                else if (do_pass)
                begin
                    if (!s.handshake_done)
                    begin
                        s.binary_done    = 1'b1;
                        s.handshake_done = 1'b1;
                        if (s.link_state != tnrn_pkg::LINK_UP)
                        begin
                            s.link_state = tnrn_pkg::LINK_UP;
                            res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_LINK, 8'd0, 8'd0, 8'd0,
                                                        8'd0, tnrn_pkg::LINK_UP);
                            n = n + 1'b1;
                        end
                    end
                    res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_DATA, rx_byte, 8'd0, 8'd0,
                                                8'd0, 2'd0);
                    n = n + 1'b1;
                end
            end
            tnrn_pkg::OP_CONNECT:
            begin
                if (s.link_state != tnrn_pkg::LINK_NEG)
                begin
                    s.link_state = tnrn_pkg::LINK_NEG;
                    res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_LINK, 8'd0, 8'd0, 8'd0,
                                                8'd0, tnrn_pkg::LINK_NEG);
                    n = n + 1'b1;
                end
                res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_REPLY, 8'd0, tnrn_pkg::CMD_DO,
                                            tnrn_pkg::OPT_BINARY, 8'd0, 2'd0);
                n = n + 1'b1;
                res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_REPLY, 8'd0, tnrn_pkg::CMD_WILL,
                                            tnrn_pkg::OPT_BINARY, 8'd0, 2'd0);
                n = n + 1'b1;
                res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_REPLY, 8'd0, tnrn_pkg::CMD_DO,
                                            tnrn_pkg::OPT_EOR, 8'd0, 2'd0);
                n = n + 1'b1;
                res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_REPLY, 8'd0, tnrn_pkg::CMD_WILL,
                                            tnrn_pkg::OPT_EOR, 8'd0, 2'd0);
                n = n + 1'b1;
            end
            tnrn_pkg::OP_DISCONNECT:
            begin
                if (s.link_state != tnrn_pkg::LINK_DOWN)
                begin
                    s.link_state = tnrn_pkg::LINK_DOWN;
                    res[n] = tnrn_pkg::make_res(tnrn_pkg::KIND_LINK, 8'd0, 8'd0, 8'd0,
                                                8'd0, tnrn_pkg::LINK_DOWN);
                    n = n + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (n != '0)
            res[n - 1'b1].last = 1'b1;

        state_next  = s;
        batch.list  = res;
        batch.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

endmodule

### src/tnrn_serializer.sv
// Result batch register: holds the results of one request and hands them
// out one per cycle while the result channel is ready. Depends on tnrn_pkg and tnrn_res_if.
module tnrn_serializer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  tnrn_pkg::batch_t       batch,
    output logic                   load_ok,
    output tnrn_pkg::ser_status_t  status,
    tnrn_res_if.source             res_ch
);

    tnrn_pkg::result_t [tnrn_pkg::MAX_RES-1:0] list_reg;
    logic [tnrn_pkg::CNT_W-1:0]               count_reg;
    logic [tnrn_pkg::CNT_W-1:0]               count_next;
    logic [tnrn_pkg::CNT_W-1:0]               head_reg;
    logic [tnrn_pkg::CNT_W-1:0]               head_next;
    logic                                     take;
    tnrn_pkg::result_t                        cur;

    assign take    = res_ch.valid && res_ch.ready;
    assign load_ok = (count_reg == '0) || (count_reg == 1'b1 && take);
    assign cur     = list_reg[head_reg];

    always_comb
    begin
        count_next = count_reg - {{(tnrn_pkg::CNT_W-1){1'b0}}, take};
        head_next  = take ? head_reg + 1'b1 : head_reg;
        if (load && batch.count != '0)
        begin
            count_next = batch.count;
            head_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && batch.count != '0)
            list_reg <= batch.list;
    end

    assign status.count      = count_reg;
    assign res_ch.valid      = count_reg != '0;
    assign res_ch.kind       = cur.kind;
    assign res_ch.data_byte  = cur.data_byte;
    assign res_ch.reply_cmd  = cur.reply_cmd;
    assign res_ch.reply_opt  = cur.reply_opt;
    assign res_ch.sub_option = cur.sub_option;
    assign res_ch.conn_state = cur.conn_state;
    assign res_ch.last       = cur.last;

endmodule

### src/telnet_receive_negotiator_unit.sv
// Telnet receive negotiator top level: parser core plus result serializer.
// The first result of a request appears in the cycle after the request is accepted.
// Throughput: one request per cycle while each yields at most one result and
// the result channel is ready; a request with more results holds the input until its last result is taken.
// Reset: rst_n async, active low; parser, flags and link state clear at once.
// Depends on tnrn_pkg, tnrn_rx_if, tnrn_res_if, tnrn_core, tnrn_serializer.
module telnet_receive_negotiator_unit (
    input  logic       clk,
    input  logic       rst_n,
    tnrn_rx_if.sink    rx_ch,
    tnrn_res_if.source res_ch
);

    tnrn_pkg::batch_t      batch;
    tnrn_pkg::ser_status_t status;
    logic                  load_ok;
    logic                  accept;

    assign rx_ch.ready = load_ok;
    assign accept      = rx_ch.valid && load_ok;

    tnrn_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (rx_ch.operation),
        .rx_byte   (rx_ch.rx_byte),
        .batch     (batch)
    );

    tnrn_serializer u_ser (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .batch   (batch),
        .load_ok (load_ok),
        .status  (status),
        .res_ch  (res_ch)
    );

    a_connect_yields: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rx_ch.operation == tnrn_pkg::OP_CONNECT |=> res_ch.valid)
        else $error("connect request produced no result");

    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        rx_ch.ready |-> status.count <= 1)
        else $error("input ready while several results pending");

    a_link_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.kind == tnrn_pkg::KIND_LINK |-> res_ch.conn_state != 2'd3)
        else $error("bad link state code");

endmodule
